FILE: design/jzwm_pkg.sv
// ----------------------------------------------------------------------------
// jzwm_pkg - shared definitions for the joystick zone wheel mixer
// Field widths, register indexes, motion codes, axis zone classes and
// reset values used by the mixer core.
// ----------------------------------------------------------------------------
package jzwm_pkg;

   // default axis width in bits
   localparam int AXIS_BITS_DEFAULT = 16;

   // fixed field widths
   localparam int GAIN_BITS  = 8;
   localparam int LIMIT_BITS = 8;
   localparam int DRIVE_BITS = 9;
   localparam int CODE_BITS  = 4;
   localparam int CSR_IDX_BITS = 2;

   // register reset values that do not depend on axis width
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 8'd100;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd100;

   // configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_DRIVE_GAIN  = 2'd0,
      REG_ZONE_HIGH   = 2'd1,
      REG_ZONE_LOW    = 2'd2,
      REG_CLAMP_LIMIT = 2'd3
   } csr_index_type;

   // axis classification against the two thresholds
   typedef enum logic [1:0] {
      ZC_MID  = 2'd0,
      ZC_LOW  = 2'd1,
      ZC_HIGH = 2'd2,
      ZC_NONE = 2'd3
   } zone_class_type;

   // motion codes
   typedef enum logic [CODE_BITS-1:0] {
      MC_STOP       = 4'd0,
      MC_FORWARD    = 4'd1,
      MC_REVERSE    = 4'd2,
      MC_LEFT       = 4'd3,
      MC_RIGHT      = 4'd4,
      MC_CCW        = 4'd5,
      MC_CW         = 4'd6,
      MC_DIAG_LF    = 4'd7,
      MC_DIAG_RR    = 4'd8,
      MC_DIAG_RF    = 4'd9,
      MC_DIAG_LR    = 4'd10
   } motion_code_type;

endpackage

FILE: design/joystick_zone_wheel_mixer_core.sv
// ----------------------------------------------------------------------------
// joystick_zone_wheel_mixer_core - joystick sample to four wheel drives
// Classes each stick axis against two thresholds, picks the first matching
// motion zone and forms the scaled, optionally clamped wheel drives.
// ----------------------------------------------------------------------------
// One result word leaves for every sample word taken, in order. The block
// takes a new sample in every cycle while results keep draining; each sample
// passes through the input register, then one pass of classify, gain
// multiply, zone select and clamp into the result register. Button A sets
// the drive enable latch, button B clears it (B wins), and the latch is
// applied to the sample that carries the press. Configuration writes take
// effect at once and are always accepted; they should only be issued while
// no sample is in flight.

module joystick_zone_wheel_mixer_core #(
   parameter int AXIS_BITS = jzwm_pkg::AXIS_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,

   // sample words
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // axis_fwd, axis_side, axis_turn, button_enable, button_disable, zero fill
   input  logic [((3*AXIS_BITS+2+7)/8)*8-1:0]   req_tdata,

   // result words
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // front_left, front_right, back_left, back_right, motion_code, zero fill
   output logic [((4*jzwm_pkg::DRIVE_BITS+jzwm_pkg::CODE_BITS+7)/8)*8-1:0] rsp_tdata,

   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [jzwm_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [AXIS_BITS-1:0]                 csr_wdata
);

   localparam int DB        = jzwm_pkg::DRIVE_BITS;
   localparam int PROD_BITS = AXIS_BITS + jzwm_pkg::GAIN_BITS + 1;
   localparam int SUM_BITS  = DB + 1;
   localparam int RSP_BITS  = ((4*DB + jzwm_pkg::CODE_BITS + 7) / 8) * 8;
   localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) <<< (AXIS_BITS-2);
   localparam logic signed [AXIS_BITS-1:0] ZONE_HIGH_RESET = AXIS_BITS'(1) << (AXIS_BITS-2);
   localparam logic signed [AXIS_BITS-1:0] ZONE_LOW_RESET  = -ZONE_HIGH_RESET;

   // configuration registers
   logic [jzwm_pkg::GAIN_BITS-1:0]  gain_ff;
   logic signed [AXIS_BITS-1:0]     zone_high_ff;
   logic signed [AXIS_BITS-1:0]     zone_low_ff;
   logic [jzwm_pkg::LIMIT_BITS-1:0] limit_ff;

   // input stage
   logic                        s1_valid_ff;
   logic signed [AXIS_BITS-1:0] s1_axis_ff [3];
   logic                        s1_btn_en_ff;
   logic                        s1_btn_dis_ff;

   // enable latch
   logic en_ff;
   logic en_in;

   // result stage
   logic                          rsp_valid_ff;
   logic signed [DB-1:0]          drive_ff [4];
   jzwm_pkg::motion_code_type     code_ff;
   logic signed [DB-1:0]          drive_in [4];
   jzwm_pkg::motion_code_type     code_in;

   logic advance;

   // datapath intermediates
   jzwm_pkg::zone_class_type     cls [3];
   logic signed [PROD_BITS-1:0]  prod [3];
   logic signed [PROD_BITS-1:0]  rounded [3];
   logic signed [DB-1:0]         scaled [3];
   logic signed [SUM_BITS-1:0]   diag_sum;
   logic signed [SUM_BITS-1:0]   diag_dif;
   logic signed [SUM_BITS-1:0]   lim_pos;
   logic signed [SUM_BITS-1:0]   lim_neg;
   logic signed [DB-1:0]         sat_sum;
   logic signed [DB-1:0]         sat_dif;

   // config port never stalls
   assign csr_ready = 1'b1;

   // configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= jzwm_pkg::GAIN_RESET;
         zone_high_ff <= ZONE_HIGH_RESET;
         zone_low_ff  <= ZONE_LOW_RESET;
         limit_ff     <= jzwm_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (jzwm_pkg::csr_index_type'(csr_index))
            jzwm_pkg::REG_DRIVE_GAIN:  gain_ff      <= csr_wdata[jzwm_pkg::GAIN_BITS-1:0];
            jzwm_pkg::REG_ZONE_HIGH:   zone_high_ff <= csr_wdata;
            jzwm_pkg::REG_ZONE_LOW:    zone_low_ff  <= csr_wdata;
            jzwm_pkg::REG_CLAMP_LIMIT: limit_ff     <= csr_wdata[jzwm_pkg::LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // pipeline flow
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   // input stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_axis_ff[0] <= req_tdata[AXIS_BITS-1:0];
         s1_axis_ff[1] <= req_tdata[2*AXIS_BITS-1:AXIS_BITS];
         s1_axis_ff[2] <= req_tdata[3*AXIS_BITS-1:2*AXIS_BITS];
         s1_btn_en_ff  <= req_tdata[3*AXIS_BITS];
         s1_btn_dis_ff <= req_tdata[3*AXIS_BITS+1];
      end
   end

   // enable latch, disable button wins
   assign en_in = (en_ff | s1_btn_en_ff) & ~s1_btn_dis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
      end else if (advance) begin
         en_ff <= en_in;
      end
   end

   // per-axis classify and gain scaling with round half up
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s1_axis_ff[i] > zone_high_ff) begin
            cls[i] = jzwm_pkg::ZC_HIGH;
         end else if (s1_axis_ff[i] < zone_low_ff) begin
            cls[i] = jzwm_pkg::ZC_LOW;
         end else if (s1_axis_ff[i] > zone_low_ff && s1_axis_ff[i] < zone_high_ff) begin
            cls[i] = jzwm_pkg::ZC_MID;
         end else begin
            cls[i] = jzwm_pkg::ZC_NONE;
         end
         prod[i]    = PROD_BITS'($signed({1'b0, gain_ff})) * PROD_BITS'(s1_axis_ff[i]);
         rounded[i] = (prod[i] + ROUND_HALF) >>> (AXIS_BITS-1);
         scaled[i]  = rounded[i][DB-1:0];
      end
   end

   // diagonal sum and difference with saturation
   always_comb begin
      diag_sum = SUM_BITS'(scaled[0]) + SUM_BITS'(scaled[1]);
      diag_dif = SUM_BITS'(scaled[0]) - SUM_BITS'(scaled[1]);
      lim_pos  = $signed({2'b00, limit_ff});
      lim_neg  = -lim_pos;
      if (diag_sum > lim_pos) begin
         sat_sum = lim_pos[DB-1:0];
      end else if (diag_sum < lim_neg) begin
         sat_sum = lim_neg[DB-1:0];
      end else begin
         sat_sum = diag_sum[DB-1:0];
      end
      if (diag_dif > lim_pos) begin
         sat_dif = lim_pos[DB-1:0];
      end else if (diag_dif < lim_neg) begin
         sat_dif = lim_neg[DB-1:0];
      end else begin
         sat_dif = diag_dif[DB-1:0];
      end
   end

   // first matching zone picks code and drives (fl, fr, bl, br)
   always_comb begin
      code_in = jzwm_pkg::MC_STOP;
      for (int k = 0; k < 4; k++) begin
         drive_in[k] = '0;
      end
      if (en_in && cls[2] == jzwm_pkg::ZC_MID) begin
         if (cls[0] == jzwm_pkg::ZC_HIGH && cls[1] == jzwm_pkg::ZC_MID) begin
            code_in = jzwm_pkg::MC_FORWARD;
            for (int k = 0; k < 4; k++) drive_in[k] = scaled[0];
         end else if (cls[0] == jzwm_pkg::ZC_LOW && cls[1] == jzwm_pkg::ZC_MID) begin
            code_in = jzwm_pkg::MC_REVERSE;
            for (int k = 0; k < 4; k++) drive_in[k] = scaled[0];
         end else if (cls[0] == jzwm_pkg::ZC_MID && cls[1] == jzwm_pkg::ZC_HIGH) begin
            code_in     = jzwm_pkg::MC_LEFT;
            drive_in[0] = -scaled[1];
            drive_in[1] = scaled[1];
            drive_in[2] = scaled[1];
            drive_in[3] = -scaled[1];
         end else if (cls[0] == jzwm_pkg::ZC_MID && cls[1] == jzwm_pkg::ZC_LOW) begin
            code_in     = jzwm_pkg::MC_RIGHT;
            drive_in[0] = -scaled[1];
            drive_in[1] = scaled[1];
            drive_in[2] = scaled[1];
            drive_in[3] = -scaled[1];
         end else if (cls[0] == jzwm_pkg::ZC_HIGH && cls[1] == jzwm_pkg::ZC_HIGH) begin
            code_in     = jzwm_pkg::MC_DIAG_LF;
            drive_in[1] = sat_sum;
            drive_in[2] = sat_sum;
         end else if (cls[0] == jzwm_pkg::ZC_LOW && cls[1] == jzwm_pkg::ZC_LOW) begin
            code_in     = jzwm_pkg::MC_DIAG_RR;
            drive_in[1] = sat_sum;
            drive_in[2] = sat_sum;
         end else if (cls[0] == jzwm_pkg::ZC_HIGH && cls[1] == jzwm_pkg::ZC_LOW) begin
            code_in     = jzwm_pkg::MC_DIAG_RF;
            drive_in[0] = sat_dif;
            drive_in[3] = sat_dif;
         end else if (cls[0] == jzwm_pkg::ZC_LOW && cls[1] == jzwm_pkg::ZC_HIGH) begin
            code_in     = jzwm_pkg::MC_DIAG_LR;
            drive_in[0] = sat_dif;
            drive_in[3] = sat_dif;
         end
      end else if (en_in && cls[0] == jzwm_pkg::ZC_MID && cls[1] == jzwm_pkg::ZC_MID) begin
         // rotation zones, turn axis out of its mid band
         if (cls[2] == jzwm_pkg::ZC_HIGH) begin
            code_in     = jzwm_pkg::MC_CCW;
            drive_in[0] = -scaled[2];
            drive_in[1] = scaled[2];
            drive_in[2] = -scaled[2];
            drive_in[3] = scaled[2];
         end else if (cls[2] == jzwm_pkg::ZC_LOW) begin
            code_in     = jzwm_pkg::MC_CW;
            drive_in[0] = -scaled[2];
            drive_in[1] = scaled[2];
            drive_in[2] = -scaled[2];
            drive_in[3] = scaled[2];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff <= drive_in;
         code_ff  <= code_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({code_ff, drive_ff[3], drive_ff[2], drive_ff[1],
                                  drive_ff[0]});

   // motion code stays within the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> code_ff <= jzwm_pkg::MC_DIAG_LR)
      else $error("motion code out of range");

   // a stop result drives no wheel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && code_ff == jzwm_pkg::MC_STOP |->
         drive_ff[0] == '0 && drive_ff[1] == '0 && drive_ff[2] == '0 && drive_ff[3] == '0)
      else $error("stop result with nonzero wheel drive");

   // a result produced with the latch cleared is a stop
   assert property (@(posedge clock) disable iff (reset)
      $past(advance) && !en_ff |-> code_ff == jzwm_pkg::MC_STOP)
      else $error("drive result while disabled");

endmodule
